// ===== design/dwspc_pkg.sv =====
// Shared types, constants and a helper function for the dual-wheel speed controller.
package dwspc_pkg;

  // Sizing.
  localparam int WHEELS     = 2;
  localparam int PULSE_BITS = 16;
  localparam int WHEEL_IW   = (WHEELS > 1) ? $clog2(WHEELS) : 1;

  localparam int SPEED_W    = 24;
  localparam int GAIN_W     = 16;
  localparam int LIMIT_W    = 24;
  localparam int ERR_W      = SPEED_W + 1;
  localparam int INTEG_W    = SPEED_W + 1;
  localparam int OPCODE_W   = 3;
  localparam int DIR_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Shared multiplier: signed A operand times zero-extended gain operand.
  localparam int MUL_A_W = (PULSE_BITS + 1 > ERR_W + 1) ? PULSE_BITS + 1 : ERR_W + 1;
  localparam int MUL_B_W = GAIN_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = PROD_W + 2;

  localparam int PERIOD_FRAC    = 16;
  localparam int GAIN_PROD_FRAC = 20;
  localparam int INC_W          = PROD_W - PERIOD_FRAC;
  localparam int PWM_Q_W        = ACC_W - 1 - GAIN_PROD_FRAC;

  // Opcodes.
  typedef enum logic [OPCODE_W-1:0] {
    OP_EDGE   = 3'd0,
    OP_TICK   = 3'd1,
    OP_TARGET = 3'd2,
    OP_DIR    = 3'd3,
    OP_STOP   = 3'd4
  } op_e;

  // Direction codes and bridge pin pairs {in2, in1}.
  localparam logic [DIR_W-1:0] DIR_BRAKE = 2'd0;
  localparam logic [DIR_W-1:0] DIR_FWD   = 2'd1;
  localparam logic [DIR_W-1:0] DIR_BACK  = 2'd2;

  localparam logic [1:0] PINS_BRAKE = 2'b11;
  localparam logic [1:0] PINS_FWD   = 2'b01;
  localparam logic [1:0] PINS_BACK  = 2'b10;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_PER_PULSE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDFORWARD_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROPORTIONAL_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_GAIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_PERIOD    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_LIMIT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_MAX           = 3'd6;

  localparam logic [GAIN_W-1:0]  RST_SPEED_PER_PULSE   = 16'd1454;
  localparam logic [GAIN_W-1:0]  RST_FEEDFORWARD_GAIN  = 16'd2376;
  localparam logic [GAIN_W-1:0]  RST_PROPORTIONAL_GAIN = 16'd1024;
  localparam logic [GAIN_W-1:0]  RST_INTEGRAL_GAIN     = 16'd2048;
  localparam logic [GAIN_W-1:0]  RST_CONTROL_PERIOD    = 16'd6554;
  localparam logic [LIMIT_W-1:0] RST_INTEGRAL_LIMIT    = 24'd102400;
  localparam logic [GAIN_W-1:0]  RST_PWM_MAX           = 16'd1000;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SPEED,
    ST_ERR,
    ST_MUL_INT,
    ST_INTEG,
    ST_MUL_FF,
    ST_MUL_P,
    ST_MUL_I,
    ST_ACC_I,
    ST_PWM
  } state_e;

  // Datapath step selected by the controller during a control tick.
  typedef enum logic [3:0] {
    TS_NONE,
    TS_MUL_SPEED,
    TS_ERR,
    TS_MUL_INT,
    TS_INTEG,
    TS_MUL_FF,
    TS_MUL_P,
    TS_MUL_I,
    TS_ACC_I,
    TS_PWM
  } tstep_e;

  typedef struct packed {
    logic   latch;
    logic   apply;
    logic   wheel_clr;
    logic   wheel_inc;
    tstep_e step;
  } cmd_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic                target_zero;
    logic                last_wheel;
  } status_t;

  typedef struct packed {
    logic [OPCODE_W-1:0]       opcode;
    logic                      wheel;
    logic                      phase_b;
    logic signed [SPEED_W-1:0] target_speed;
    logic [DIR_W-1:0]          direction;
  } item_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  left_pwm;
    logic [GAIN_W-1:0]  right_pwm;
    logic [SPEED_W-1:0] left_speed;
    logic [SPEED_W-1:0] right_speed;
    logic               left_in1;
    logic               left_in2;
    logic               right_in1;
    logic               right_in2;
  } snap_t;

  // Bridge pins for a direction code; the right wheel is mounted mirrored.
  function automatic logic [1:0] pins_for(input logic is_right, input logic [DIR_W-1:0] dir);
    logic [DIR_W-1:0] d;
    logic [1:0]       pins;
    d = dir;
    if (is_right) begin
      if (dir == DIR_FWD) begin
        d = DIR_BACK;
      end else if (dir == DIR_BACK) begin
        d = DIR_FWD;
      end
    end
    case (d)
      DIR_BRAKE: pins = PINS_BRAKE;
      DIR_FWD:   pins = PINS_FWD;
      default:   pins = PINS_BACK;
    endcase
    return pins;
  endfunction

endpackage

// ===== design/dwspc_if.sv =====
// Handshake interfaces for the command, result and configuration channels.
interface dwspc_in_if;
  import dwspc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [OPCODE_W-1:0]       opcode;
  logic                      wheel;
  logic                      phase_b;
  logic signed [SPEED_W-1:0] target_speed;
  logic [DIR_W-1:0]          direction;

  modport source (output valid, opcode, wheel, phase_b, target_speed, direction,
                  input ready);
  modport sink (input valid, opcode, wheel, phase_b, target_speed, direction,
                output ready);
endinterface

interface dwspc_out_if;
  import dwspc_pkg::*;
  logic               valid;
  logic               ready;
  logic [GAIN_W-1:0]  left_pwm;
  logic [GAIN_W-1:0]  right_pwm;
  logic [SPEED_W-1:0] left_speed;
  logic [SPEED_W-1:0] right_speed;
  logic               left_in1;
  logic               left_in2;
  logic               right_in1;
  logic               right_in2;

  modport source (output valid, left_pwm, right_pwm, left_speed, right_speed,
                  left_in1, left_in2, right_in1, right_in2, input ready);
  modport sink (input valid, left_pwm, right_pwm, left_speed, right_speed,
                left_in1, left_in2, right_in1, right_in2, output ready);
endinterface

interface dwspc_cfg_if;
  import dwspc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/dual_wheel_speed_pi_controller_top.sv =====
// Top level of the dual-wheel speed controller with PI loop and feedforward.
// Simple opcodes (encoder, set-target, set-direction, stop-all and unused) register
// the command on acceptance and apply it in the EXEC state; a control tick then walks
// SPEED, ERR and the PI steps for each wheel, skipping the PI steps for a zero target.
// A new command is taken only once the previous one is through, since the tick
// sequence walks the single shared multiplier per wheel.
// Reset clears counts, targets, speeds, integrals and PWM, brakes both bridges and
// loads the configuration defaults; the block is ready in the first cycle after reset.
module dual_wheel_speed_pi_controller_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  dwspc_in_if.sink    in_i,
  dwspc_out_if.source out_o,
  dwspc_cfg_if.sink   cfg_i
);
  import dwspc_pkg::*;

  item_t   item;
  cmd_t    cmd;
  status_t status;
  snap_t   snap;

  // The incoming transaction payload travels to the datapath as one struct; it
  // is captured there on the accepting edge.
  assign item.opcode       = in_i.opcode;
  assign item.wheel        = in_i.wheel;
  assign item.phase_b      = in_i.phase_b;
  assign item.target_speed = in_i.target_speed;
  assign item.direction    = in_i.direction;

  // The controller owns both handshakes. A new command is taken only once the
  // previous result has been taken (or is taken in the same cycle), so the
  // architectural state registers can drive the result channel directly.
  dwspc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath holds the configuration registers, the per-wheel state and
  // the one multiplier that the tick sequence shares between both wheels.
  dwspc_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_i),
    .item_i   (item),
    .cmd_i    (cmd),
    .status_o (status),
    .snap_o   (snap)
  );

  // Result payload is the snapshot of both wheels after the last command.
  assign out_o.left_pwm    = snap.left_pwm;
  assign out_o.right_pwm   = snap.right_pwm;
  assign out_o.left_speed  = snap.left_speed;
  assign out_o.right_speed = snap.right_speed;
  assign out_o.left_in1    = snap.left_in1;
  assign out_o.left_in2    = snap.left_in2;
  assign out_o.right_in1   = snap.right_in1;
  assign out_o.right_in2   = snap.right_in2;

endmodule

// ===== design/dwspc_ctrl.sv =====
// Controller state machine: transaction handshakes and control tick sequencing.
module dwspc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  dwspc_pkg::status_t status_i,
  output dwspc_pkg::cmd_t    cmd_o
);
  import dwspc_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   done;
  logic   is_tick;

  assign is_tick    = (status_i.opcode == OP_TICK);
  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = is_tick ? ST_SPEED : ST_IDLE;
      end
      ST_SPEED:   state_d = ST_ERR;
      ST_ERR: begin
        if (status_i.target_zero) begin
          state_d = status_i.last_wheel ? ST_IDLE : ST_SPEED;
        end else begin
          state_d = ST_MUL_INT;
        end
      end
      ST_MUL_INT: state_d = ST_INTEG;
      ST_INTEG:   state_d = ST_MUL_FF;
      ST_MUL_FF:  state_d = ST_MUL_P;
      ST_MUL_P:   state_d = ST_MUL_I;
      ST_MUL_I:   state_d = ST_ACC_I;
      ST_ACC_I:   state_d = ST_PWM;
      ST_PWM: begin
        state_d = status_i.last_wheel ? ST_IDLE : ST_SPEED;
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  // Outputs to the datapath.
  always_comb begin
    cmd_o           = '0;
    cmd_o.step      = TS_NONE;
    done            = 1'b0;
    cmd_o.latch     = in_valid_i && in_ready_o;
    case (state_q)
      ST_EXEC: begin
        cmd_o.apply     = 1'b1;
        cmd_o.wheel_clr = is_tick;
        done            = !is_tick;
      end
      ST_SPEED:   cmd_o.step = TS_MUL_SPEED;
      ST_ERR: begin
        cmd_o.step      = TS_ERR;
        cmd_o.wheel_inc = status_i.target_zero && !status_i.last_wheel;
        done            = status_i.target_zero && status_i.last_wheel;
      end
      ST_MUL_INT: cmd_o.step = TS_MUL_INT;
      ST_INTEG:   cmd_o.step = TS_INTEG;
      ST_MUL_FF:  cmd_o.step = TS_MUL_FF;
      ST_MUL_P:   cmd_o.step = TS_MUL_P;
      ST_MUL_I:   cmd_o.step = TS_MUL_I;
      ST_ACC_I:   cmd_o.step = TS_ACC_I;
      ST_PWM: begin
        cmd_o.step      = TS_PWM;
        cmd_o.wheel_inc = !status_i.last_wheel;
        done            = status_i.last_wheel;
      end
      default: begin
        cmd_o.step = TS_NONE;
      end
    endcase
  end

  assign out_valid_d = done || (out_valid_q && !out_ready_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== design/dwspc_datapath.sv =====
// Datapath: configuration registers, per-wheel state and the shared multiplier.
module dwspc_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  dwspc_cfg_if.sink        cfg_i,
  input  dwspc_pkg::item_t item_i,
  input  dwspc_pkg::cmd_t  cmd_i,
  output dwspc_pkg::status_t status_o,
  output dwspc_pkg::snap_t snap_o
);
  import dwspc_pkg::*;

  localparam logic signed [PULSE_BITS-1:0] CNT_MAX = {1'b0, {(PULSE_BITS-1){1'b1}}};
  localparam logic signed [PULSE_BITS-1:0] CNT_MIN = {1'b1, {(PULSE_BITS-1){1'b0}}};

  // Configuration registers.
  logic [GAIN_W-1:0]  spp_q, ff_q, kp_q, ki_q, period_q, pwm_max_q;
  logic [LIMIT_W-1:0] limit_q;

  // Latched command item.
  logic [OPCODE_W-1:0]       opcode_q;
  logic                      phase_q;
  logic signed [SPEED_W-1:0] tspeed_q;
  logic [DIR_W-1:0]          dir_q;
  logic                      ok_q;
  logic [WHEEL_IW-1:0]       widx_q;

  // Per-wheel state.
  logic signed [PULSE_BITS-1:0] count_q [WHEELS];
  logic signed [PULSE_BITS-1:0] count_d [WHEELS];
  logic [SPEED_W-1:0]           target_q [WHEELS];
  logic [SPEED_W-1:0]           target_d [WHEELS];
  logic [SPEED_W-1:0]           meas_q [WHEELS];
  logic [SPEED_W-1:0]           meas_d [WHEELS];
  logic signed [INTEG_W-1:0]    integral_q [WHEELS];
  logic signed [INTEG_W-1:0]    integral_d [WHEELS];
  logic [GAIN_W-1:0]            pwm_q [WHEELS];
  logic [GAIN_W-1:0]            pwm_d [WHEELS];
  logic [1:0]                   pins_q [WHEELS];
  logic [1:0]                   pins_d [WHEELS];

  // Tick working registers.
  logic signed [MUL_A_W-1:0] mul_a;
  logic [GAIN_W-1:0]         mul_b;
  logic signed [PROD_W-1:0]  prod_d, prod_q;
  logic signed [ERR_W-1:0]   err_d, err_q;
  logic signed [INTEG_W-1:0] integ_q;
  logic signed [ACC_W-1:0]   acc_q;

  logic signed [PULSE_BITS-1:0] cnt_cur;
  logic [PULSE_BITS-1:0]        mag;
  logic [SPEED_W-1:0]           meas_sat;
  logic signed [INC_W-1:0]      inc;
  logic signed [INC_W:0]        integ_sum, lim_pos, lim_neg, integ_clamp;
  logic signed [INTEG_W-1:0]    integ_new;
  logic [PWM_Q_W-1:0]           pwm_raw;
  logic [GAIN_W-1:0]            pwm_new;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spp_q     <= RST_SPEED_PER_PULSE;
      ff_q      <= RST_FEEDFORWARD_GAIN;
      kp_q      <= RST_PROPORTIONAL_GAIN;
      ki_q      <= RST_INTEGRAL_GAIN;
      period_q  <= RST_CONTROL_PERIOD;
      limit_q   <= RST_INTEGRAL_LIMIT;
      pwm_max_q <= RST_PWM_MAX;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_SPEED_PER_PULSE:   spp_q     <= cfg_i.data[GAIN_W-1:0];
        CFG_FEEDFORWARD_GAIN:  ff_q      <= cfg_i.data[GAIN_W-1:0];
        CFG_PROPORTIONAL_GAIN: kp_q      <= cfg_i.data[GAIN_W-1:0];
        CFG_INTEGRAL_GAIN:     ki_q      <= cfg_i.data[GAIN_W-1:0];
        CFG_CONTROL_PERIOD:    period_q  <= cfg_i.data[GAIN_W-1:0];
        CFG_INTEGRAL_LIMIT:    limit_q   <= cfg_i.data[LIMIT_W-1:0];
        CFG_PWM_MAX:           pwm_max_q <= cfg_i.data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Item capture; the wheel index also selects the tick's current wheel.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      opcode_q <= item_i.opcode;
      phase_q  <= item_i.phase_b;
      tspeed_q <= item_i.target_speed;
      dir_q    <= item_i.direction;
      ok_q     <= 32'(item_i.wheel) < 32'(WHEELS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      widx_q <= '0;
    end else if (cmd_i.latch) begin
      widx_q <= WHEEL_IW'(item_i.wheel);
    end else if (cmd_i.wheel_clr) begin
      widx_q <= '0;
    end else if (cmd_i.wheel_inc) begin
      widx_q <= widx_q + WHEEL_IW'(1);
    end
  end

  assign status_o.opcode      = opcode_q;
  assign status_o.target_zero = (target_q[widx_q] == '0);
  assign status_o.last_wheel  = (widx_q == WHEEL_IW'(WHEELS - 1));

  // Shared multiplier with registered product.
  assign cnt_cur = count_q[widx_q];
  assign mag     = cnt_cur[PULSE_BITS-1] ? PULSE_BITS'(-cnt_cur) : PULSE_BITS'(cnt_cur);

  always_comb begin
    case (cmd_i.step)
      TS_MUL_SPEED: begin
        mul_a = MUL_A_W'(mag);
        mul_b = spp_q;
      end
      TS_MUL_INT: begin
        mul_a = MUL_A_W'(err_q);
        mul_b = period_q;
      end
      TS_MUL_FF: begin
        mul_a = MUL_A_W'(target_q[widx_q]);
        mul_b = ff_q;
      end
      TS_MUL_P: begin
        mul_a = MUL_A_W'(err_q);
        mul_b = kp_q;
      end
      TS_MUL_I: begin
        mul_a = MUL_A_W'(integ_q);
        mul_b = ki_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * $signed({1'b0, mul_b});

  // Speed saturation, error, integral update and PWM clamp.
  assign meas_sat = (prod_q[PROD_W-1:SPEED_W] != '0) ? {SPEED_W{1'b1}}
                                                     : prod_q[SPEED_W-1:0];
  assign err_d    = $signed({1'b0, target_q[widx_q]}) - $signed({1'b0, meas_sat});

  assign inc         = $signed(prod_q[PROD_W-1:PERIOD_FRAC]);
  assign integ_sum   = (INC_W+1)'(inc) + (INC_W+1)'(integral_q[widx_q]);
  assign lim_pos     = $signed((INC_W+1)'(limit_q));
  assign lim_neg     = -lim_pos;
  assign integ_clamp = (integ_sum > lim_pos) ? lim_pos :
                       (integ_sum < lim_neg) ? lim_neg : integ_sum;
  assign integ_new   = integ_clamp[INTEG_W-1:0];

  assign pwm_raw = acc_q[ACC_W-2:GAIN_PROD_FRAC];
  assign pwm_new = acc_q[ACC_W-1] ? '0 :
                   (pwm_raw > PWM_Q_W'(pwm_max_q)) ? pwm_max_q : pwm_raw[GAIN_W-1:0];

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (cmd_i.step == TS_ERR) begin
      err_q <= err_d;
    end
    if (cmd_i.step == TS_INTEG) begin
      integ_q <= integ_new;
    end
    if (cmd_i.step == TS_MUL_P) begin
      acc_q <= ACC_W'(prod_q);
    end else if (cmd_i.step == TS_MUL_I || cmd_i.step == TS_ACC_I) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // Per-wheel state update.
  always_comb begin
    count_d    = count_q;
    target_d   = target_q;
    meas_d     = meas_q;
    integral_d = integral_q;
    pwm_d      = pwm_q;
    pins_d     = pins_q;
    if (cmd_i.apply) begin
      case (opcode_q)
        OP_EDGE: begin
          if (ok_q) begin
            if (phase_q) begin
              if (cnt_cur != CNT_MAX) begin
                count_d[widx_q] = cnt_cur + PULSE_BITS'(1);
              end
            end else if (cnt_cur != CNT_MIN) begin
              count_d[widx_q] = cnt_cur - PULSE_BITS'(1);
            end
          end
        end
        OP_TARGET: begin
          if (ok_q) begin
            target_d[widx_q] = tspeed_q[SPEED_W-1] ? '0 : SPEED_W'(tspeed_q);
          end
        end
        OP_DIR: begin
          if (ok_q) begin
            pins_d[widx_q] = pins_for(widx_q == WHEEL_IW'(1), dir_q);
          end
        end
        OP_STOP: begin
          for (int w = 0; w < WHEELS; w++) begin
            count_d[w]    = '0;
            target_d[w]   = '0;
            meas_d[w]     = '0;
            integral_d[w] = '0;
            pwm_d[w]      = '0;
            pins_d[w]     = PINS_BRAKE;
          end
        end
        default: begin
        end
      endcase
    end
    case (cmd_i.step)
      TS_ERR: begin
        meas_d[widx_q]  = meas_sat;
        count_d[widx_q] = '0;
        if (target_q[widx_q] == '0) begin
          integral_d[widx_q] = '0;
          pwm_d[widx_q]      = '0;
        end
      end
      TS_INTEG: integral_d[widx_q] = integ_new;
      TS_PWM:   pwm_d[widx_q]      = pwm_new;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < WHEELS; w++) begin
        count_q[w]    <= '0;
        target_q[w]   <= '0;
        meas_q[w]     <= '0;
        integral_q[w] <= '0;
        pwm_q[w]      <= '0;
        pins_q[w]     <= PINS_BRAKE;
      end
    end else begin
      count_q    <= count_d;
      target_q   <= target_d;
      meas_q     <= meas_d;
      integral_q <= integral_d;
      pwm_q      <= pwm_d;
      pins_q     <= pins_d;
    end
  end

  // Result snapshot: left is wheel zero, right is wheel one when present.
  assign snap_o.left_pwm   = pwm_q[0];
  assign snap_o.left_speed = meas_q[0];
  assign snap_o.left_in1   = pins_q[0][0];
  assign snap_o.left_in2   = pins_q[0][1];

  if (WHEELS > 1) begin : g_right
    assign snap_o.right_pwm   = pwm_q[1];
    assign snap_o.right_speed = meas_q[1];
    assign snap_o.right_in1   = pins_q[1][0];
    assign snap_o.right_in2   = pins_q[1][1];
  end else begin : g_no_right
    assign snap_o.right_pwm   = '0;
    assign snap_o.right_speed = '0;
    assign snap_o.right_in1   = 1'b0;
    assign snap_o.right_in2   = 1'b0;
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the dual-wheel speed controller with a built-in predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dwspc_pkg::*;

  // Run control.
  localparam int          RST_CYCLES    = 6;
  // The slowest correct run is about 1100 commands plus one long receiver hold-off,
  // so CYCLE_LIMIT leaves a wide margin.
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  // Longer than the slowest control tick, used once the queue is empty.
  localparam int          SETTLE_CYCLES = 24;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned IDLE_PCT      = 56;
  localparam int unsigned BOTH_IDLE_PCT = 29;
  localparam int unsigned PHASE_ITEMS   = 230;
  localparam int unsigned PRESSURE_ITEMS = 60;

  // Wheel indexes and codes that the package leaves unnamed.
  localparam int                   LEFT         = 0;
  localparam int                   RIGHT        = 1;
  localparam logic [OPCODE_W-1:0]  OP_UNUSED_LO = OPCODE_W'(OP_STOP + 1);
  localparam logic [OPCODE_W-1:0]  OP_UNUSED_HI = '1;
  localparam logic [DIR_W-1:0]     DIR_SPARE    = '1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED   = '1;

  // Arithmetic bounds of the controller.
  localparam longint SPEED_CEIL = (64'sd1 <<< SPEED_W) - 1;
  localparam longint COUNT_HI   = (64'sd1 <<< (PULSE_BITS - 1)) - 1;
  localparam longint COUNT_LO   = -COUNT_HI - 1;
  localparam int     BURST_EDGES = 40;

  logic clk_i;
  logic rst_ni;

  dwspc_in_if  cmd_if ();
  dwspc_out_if snap_if ();
  dwspc_cfg_if reg_if ();

  dual_wheel_speed_pi_controller_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (snap_if),
    .cfg_i  (reg_if)
  );

  // Predictor copy of the configuration registers.
  logic [GAIN_W-1:0]  cfg_spp;
  logic [GAIN_W-1:0]  cfg_ff;
  logic [GAIN_W-1:0]  cfg_kp;
  logic [GAIN_W-1:0]  cfg_ki;
  logic [GAIN_W-1:0]  cfg_period;
  logic [LIMIT_W-1:0] cfg_integ_limit;
  logic [GAIN_W-1:0]  cfg_pwm_max;

  // Predictor copy of the per-wheel state.
  logic signed [PULSE_BITS-1:0] pulse_cnt  [WHEELS];
  logic [SPEED_W-1:0]           tgt_speed  [WHEELS];
  logic [SPEED_W-1:0]           meas_speed [WHEELS];
  logic signed [INTEG_W-1:0]    integ_acc  [WHEELS];
  logic [GAIN_W-1:0]            pwm_cmp    [WHEELS];
  logic [1:0]                   bridge     [WHEELS];  // {in2, in1}

  // Snapshots that the block still owes, oldest first.
  snap_t expected_snaps [$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_request   = 1'b0;
  int unsigned hold_left      = 0;
  int unsigned fail_count     = 0;
  int unsigned items_sent     = 0;
  int unsigned cycle_count    = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor.
  // ---------------------------------------------------------------------------

  function automatic void clear_wheels();
    for (int w = 0; w < WHEELS; w++) begin
      pulse_cnt[w]  = '0;
      tgt_speed[w]  = '0;
      meas_speed[w] = '0;
      integ_acc[w]  = '0;
      pwm_cmp[w]    = '0;
      bridge[w]     = PINS_BRAKE;
    end
  endfunction

  function automatic void reset_model();
    cfg_spp         = RST_SPEED_PER_PULSE;
    cfg_ff          = RST_FEEDFORWARD_GAIN;
    cfg_kp          = RST_PROPORTIONAL_GAIN;
    cfg_ki          = RST_INTEGRAL_GAIN;
    cfg_period      = RST_CONTROL_PERIOD;
    cfg_integ_limit = RST_INTEGRAL_LIMIT;
    cfg_pwm_max     = RST_PWM_MAX;
    clear_wheels();
  endfunction

  // Only the low bits that a register holds are kept; the spare index is ignored.
  function automatic void store_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] value);
    case (idx)
      CFG_SPEED_PER_PULSE:   cfg_spp         = value[GAIN_W-1:0];
      CFG_FEEDFORWARD_GAIN:  cfg_ff          = value[GAIN_W-1:0];
      CFG_PROPORTIONAL_GAIN: cfg_kp          = value[GAIN_W-1:0];
      CFG_INTEGRAL_GAIN:     cfg_ki          = value[GAIN_W-1:0];
      CFG_CONTROL_PERIOD:    cfg_period      = value[GAIN_W-1:0];
      CFG_INTEGRAL_LIMIT:    cfg_integ_limit = value[LIMIT_W-1:0];
      CFG_PWM_MAX:           cfg_pwm_max     = value[GAIN_W-1:0];
      default: ;
    endcase
  endfunction

  // One wheel's share of a control tick: measure, then run the PI loop.
  function automatic void run_wheel_tick(input int w);
    longint mag;
    longint spd;
    longint err;
    longint acc;
    longint sum;
    longint duty;
    mag = longint'(pulse_cnt[w]);
    if (mag < 0) mag = -mag;
    spd = mag * longint'(cfg_spp);
    pulse_cnt[w] = '0;
    meas_speed[w] = (spd > SPEED_CEIL) ? {SPEED_W{1'b1}} : spd[SPEED_W-1:0];
    if (tgt_speed[w] == '0) begin
      // A zero target parks the wheel and forgets the integral.
      integ_acc[w] = '0;
      pwm_cmp[w]   = '0;
    end else begin
      err = longint'(tgt_speed[w]) - longint'(meas_speed[w]);
      // The arithmetic shift rounds toward minus infinity, as the block does.
      acc = longint'(integ_acc[w]) + ((err * longint'(cfg_period)) >>> PERIOD_FRAC);
      if (acc > longint'(cfg_integ_limit)) acc = longint'(cfg_integ_limit);
      if (acc < -longint'(cfg_integ_limit)) acc = -longint'(cfg_integ_limit);
      integ_acc[w] = acc[INTEG_W-1:0];
      sum = longint'(cfg_ff) * longint'(tgt_speed[w]) + longint'(cfg_kp) * err
          + longint'(cfg_ki) * acc;
      if (sum < 0) begin
        pwm_cmp[w] = '0;
      end else begin
        duty = sum >>> GAIN_PROD_FRAC;
        pwm_cmp[w] = (duty > longint'(cfg_pwm_max)) ? cfg_pwm_max : duty[GAIN_W-1:0];
      end
    end
  endfunction

  // The right wheel is mounted mirrored, so forward and backward trade places there.
  // The spare direction code is not mirrored and always drives in2.
  function automatic logic [1:0] pins_from_dir(input int w, input logic [DIR_W-1:0] dir);
    logic [1:0] pins;
    if (dir == DIR_BRAKE) begin
      pins = PINS_BRAKE;
    end else if ((dir == DIR_FWD && w != RIGHT) || (dir == DIR_BACK && w == RIGHT)) begin
      pins = PINS_FWD;
    end else begin
      pins = PINS_BACK;
    end
    return pins;
  endfunction

  // Applies one accepted command and returns the snapshot the block must report.
  function automatic snap_t apply_cmd(input item_t it);
    snap_t  s;
    int     w;
    longint c;
    w = int'(it.wheel);
    case (it.opcode)
      OP_EDGE: begin
        c = longint'(pulse_cnt[w]) + (it.phase_b ? 1 : -1);
        if (c > COUNT_HI) c = COUNT_HI;
        if (c < COUNT_LO) c = COUNT_LO;
        pulse_cnt[w] = c[PULSE_BITS-1:0];
      end
      OP_TICK: begin
        for (int i = 0; i < WHEELS; i++) run_wheel_tick(i);
      end
      OP_TARGET: tgt_speed[w] = it.target_speed[SPEED_W-1] ? '0 : it.target_speed;
      OP_DIR:    bridge[w] = pins_from_dir(w, it.direction);
      OP_STOP:   clear_wheels();
      default: ;
    endcase
    s.left_pwm    = pwm_cmp[LEFT];
    s.right_pwm   = pwm_cmp[RIGHT];
    s.left_speed  = meas_speed[LEFT];
    s.right_speed = meas_speed[RIGHT];
    s.left_in1    = bridge[LEFT][0];
    s.left_in2    = bridge[LEFT][1];
    s.right_in1   = bridge[RIGHT][0];
    s.right_in2   = bridge[RIGHT][1];
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. Inputs change at the falling edge; every task starts and ends there.
  // ---------------------------------------------------------------------------

  function automatic item_t make_cmd(input logic [OPCODE_W-1:0] op, input logic wheel,
                                     input logic phase_b, input logic [SPEED_W-1:0] target,
                                     input logic [DIR_W-1:0] dir);
    item_t it;
    it.opcode       = op;
    it.wheel        = wheel;
    it.phase_b      = phase_b;
    it.target_speed = target;
    it.direction    = dir;
    return it;
  endfunction

  function automatic item_t random_raw_cmd();
    return make_cmd(OPCODE_W'($urandom), 1'($urandom), 1'($urandom), SPEED_W'($urandom),
                    DIR_W'($urandom));
  endfunction

  // Mostly plausible speeds, with zero, negative and full-range values mixed in.
  function automatic logic [SPEED_W-1:0] random_target();
    logic [SPEED_W-1:0] t;
    case ($urandom_range(0, 9))
      0:       t = '0;
      1:       t = {1'b1, (SPEED_W - 1)'($urandom)};
      2:       t = SPEED_W'($urandom);
      default: t = SPEED_W'($urandom_range(0, 32'h20000));
    endcase
    return t;
  endfunction

  // Offers one command, waits for the transaction, and records its expected snapshot.
  // Valid stays high afterwards so back-to-back commands need no extra edge.
  task automatic send_cmd(input item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    cmd_if.valid        <= 1'b1;
    cmd_if.opcode       <= it.opcode;
    cmd_if.wheel        <= it.wheel;
    cmd_if.phase_b      <= it.phase_b;
    cmd_if.target_speed <= it.target_speed;
    cmd_if.direction    <= it.direction;
    @(posedge clk_i);
    while (cmd_if.ready !== 1'b1) @(posedge clk_i);
    expected_snaps.push_back(apply_cmd(it));
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    reg_if.valid <= 1'b1;
    reg_if.index <= idx;
    reg_if.data  <= value;
    @(posedge clk_i);
    while (reg_if.ready !== 1'b1) @(posedge clk_i);
    store_reg(idx, value);
    @(negedge clk_i);
  endtask

  // Stops offering commands and waits until every snapshot has arrived and the
  // block has had time to go quiet.
  task automatic wait_idle();
    cmd_if.valid <= 1'b0;
    while (expected_snaps.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Writes every register while the block is idle; the spare index may be written too.
  task automatic apply_setting(input logic [CFG_DATA_W-1:0] spp, ff, kp, ki, period, limit,
                               pmax, input bit touch_spare);
    wait_idle();
    write_reg(CFG_SPEED_PER_PULSE, spp);
    write_reg(CFG_FEEDFORWARD_GAIN, ff);
    write_reg(CFG_PROPORTIONAL_GAIN, kp);
    write_reg(CFG_INTEGRAL_GAIN, ki);
    write_reg(CFG_CONTROL_PERIOD, period);
    write_reg(CFG_INTEGRAL_LIMIT, limit);
    write_reg(CFG_PWM_MAX, pmax);
    if (touch_spare) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
    reg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      snap_if.ready <= 1'b0;
    end else begin
      snap_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Checking. Each snapshot transaction is matched against the oldest expectation.
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string name, input logic [SPEED_W-1:0] want,
                                      input logic [SPEED_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin : snap_check
    snap_t want;
    if (rst_ni === 1'b1 && snap_if.valid === 1'b1 && snap_if.ready === 1'b1) begin
      if (expected_snaps.size() == 0) begin
        $error("snapshot transaction with no command waiting for it");
        fail_count++;
      end else begin
        want = expected_snaps.pop_front();
        check_field("left_pwm", SPEED_W'(want.left_pwm), SPEED_W'(snap_if.left_pwm));
        check_field("right_pwm", SPEED_W'(want.right_pwm), SPEED_W'(snap_if.right_pwm));
        check_field("left_speed", want.left_speed, snap_if.left_speed);
        check_field("right_speed", want.right_speed, snap_if.right_speed);
        check_field("left_in1", SPEED_W'(want.left_in1), SPEED_W'(snap_if.left_in1));
        check_field("left_in2", SPEED_W'(want.left_in2), SPEED_W'(snap_if.left_in2));
        check_field("right_in1", SPEED_W'(want.right_in1), SPEED_W'(snap_if.right_in1));
        check_field("right_in2", SPEED_W'(want.right_in2), SPEED_W'(snap_if.right_in2));
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Unused opcodes leave the state alone and just report the reset snapshot.
  task automatic test_unused_opcodes();
    send_cmd(make_cmd(OP_UNUSED_LO, 1'b0, 1'b0, '0, DIR_BRAKE));
    send_cmd(make_cmd(OP_UNUSED_HI, 1'b1, 1'b1, '1, DIR_SPARE));
  endtask

  // Every direction code on both wheels, ending away from brake so stop-all shows.
  task automatic test_bridge_directions();
    for (int w = 0; w < WHEELS; w++) begin
      send_cmd(make_cmd(OP_DIR, 1'(w), 1'b0, '0, DIR_BRAKE));
      send_cmd(make_cmd(OP_DIR, 1'(w), 1'b1, '0, DIR_SPARE));
      send_cmd(make_cmd(OP_DIR, 1'(w), 1'b0, '0, DIR_BACK));
      send_cmd(make_cmd(OP_DIR, 1'(w), 1'b1, '0, DIR_FWD));
    end
  endtask

  // Target extremes, negative targets, a clamped PWM, a negative PI sum, and the
  // zero-target path through a tick.
  task automatic test_targets_and_ticks();
    send_cmd(make_cmd(OP_TARGET, 1'b0, 1'b0, 24'h7FFFFF, DIR_BRAKE));
    send_cmd(make_cmd(OP_TARGET, 1'b1, 1'b0, 24'h800000, DIR_BRAKE));
    send_cmd(make_cmd(OP_TARGET, 1'b1, 1'b0, 24'hFFFFFF, DIR_BRAKE));
    send_cmd(make_cmd(OP_TARGET, 1'b1, 1'b0, 24'h000100, DIR_BRAKE));
    repeat (3) begin
      send_cmd(make_cmd(OP_EDGE, 1'b0, 1'b1, '0, DIR_BRAKE));
      send_cmd(make_cmd(OP_EDGE, 1'b1, 1'b0, '0, DIR_BRAKE));
    end
    // The wheel field of a tick is ignored; both wheels update.
    send_cmd(make_cmd(OP_TICK, 1'b1, 1'b0, '0, DIR_BRAKE));
    send_cmd(make_cmd(OP_TARGET, 1'b0, 1'b0, '0, DIR_BRAKE));
    send_cmd(make_cmd(OP_TICK, 1'b0, 1'b1, '0, DIR_BRAKE));
    send_cmd(make_cmd(OP_TICK, 1'b1, 1'b1, '1, DIR_SPARE));
  endtask

  task automatic test_stop_all();
    send_cmd(make_cmd(OP_STOP, 1'b0, 1'b0, '0, DIR_FWD));
  endtask

  // A long run of edges counting up on the left and down on the right; with one
  // unit per pulse the measured speed shows the count.
  task automatic test_edge_burst();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    apply_setting(CFG_DATA_W'(1), CFG_DATA_W'(RST_FEEDFORWARD_GAIN),
                  CFG_DATA_W'(RST_PROPORTIONAL_GAIN), CFG_DATA_W'(RST_INTEGRAL_GAIN),
                  CFG_DATA_W'(RST_CONTROL_PERIOD), CFG_DATA_W'(RST_INTEGRAL_LIMIT),
                  CFG_DATA_W'(RST_PWM_MAX), 1'b0);
    repeat (BURST_EDGES) begin
      send_cmd(make_cmd(OP_EDGE, 1'b0, 1'b1, '0, DIR_BRAKE));
      send_cmd(make_cmd(OP_EDGE, 1'b1, 1'b0, '0, DIR_BRAKE));
    end
    send_cmd(make_cmd(OP_TICK, 1'b0, 1'b0, '0, DIR_BRAKE));
  endtask

  // Control periods with random content: targets and directions now and then, a burst
  // of encoder edges that mostly agree on direction, then a tick. Raw random commands
  // and stop-all are mixed in as noise.
  task automatic test_random_control(input int unsigned n_items);
    int unsigned       stop_at;
    int unsigned       burst;
    logic              w;
    logic [WHEELS-1:0] up_bias;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      up_bias = WHEELS'($urandom);
      if ($urandom_range(0, 2) == 0) begin
        send_cmd(make_cmd(OP_TARGET, 1'($urandom), 1'($urandom), random_target(),
                          DIR_W'($urandom)));
      end
      if ($urandom_range(0, 5) == 0) begin
        send_cmd(make_cmd(OP_DIR, 1'($urandom), 1'($urandom), SPEED_W'($urandom),
                          DIR_W'($urandom)));
      end
      burst = ($urandom_range(0, 29) == 0) ? $urandom_range(0, 200) : $urandom_range(0, 8);
      repeat (burst) begin
        w = 1'($urandom);
        send_cmd(make_cmd(OP_EDGE, w, ($urandom_range(0, 9) == 0) ? !up_bias[w] : up_bias[w],
                          SPEED_W'($urandom), DIR_W'($urandom)));
      end
      if ($urandom_range(0, 19) != 0) begin
        send_cmd(make_cmd(OP_TICK, 1'($urandom), 1'($urandom), SPEED_W'($urandom),
                          DIR_W'($urandom)));
      end
      if ($urandom_range(0, 9) == 0) send_cmd(random_raw_cmd());
      if ($urandom_range(0, 49) == 0) begin
        send_cmd(make_cmd(OP_STOP, 1'($urandom), 1'($urandom), SPEED_W'($urandom),
                          DIR_W'($urandom)));
      end
    end
  endtask

  // The receiver holds off for a long stretch while commands keep coming, so the
  // block fills up and has to stall its input.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    apply_setting(CFG_DATA_W'($urandom_range(500, 3000)),
                  CFG_DATA_W'($urandom_range(0, 8000)),
                  CFG_DATA_W'($urandom_range(0, 8000)),
                  CFG_DATA_W'($urandom_range(0, 8000)),
                  CFG_DATA_W'($urandom_range(1000, 20000)),
                  CFG_DATA_W'($urandom_range(0, 400000)),
                  CFG_DATA_W'($urandom_range(1, 2000)), 1'b1);
    hold_request = 1'b1;
    test_random_control(PRESSURE_ITEMS);
  endtask

  initial begin
    rst_ni              = 1'b0;
    cmd_if.valid        = 1'b0;
    cmd_if.opcode       = OP_EDGE;
    cmd_if.wheel        = 1'b0;
    cmd_if.phase_b      = 1'b0;
    cmd_if.target_speed = '0;
    cmd_if.direction    = DIR_BRAKE;
    snap_if.ready       = 1'b0;
    reg_if.valid        = 1'b0;
    reg_if.index        = CFG_SPEED_PER_PULSE;
    reg_if.data         = '0;
    reset_model();
    repeat (RST_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part, without idling; all but the edge burst run at the reset configuration.
    test_unused_opcodes();
    test_bridge_directions();
    test_targets_and_ticks();
    test_stop_all();
    test_edge_burst();

    // Random part, one configuration and one idling pattern per phase.
    apply_setting(CFG_DATA_W'(RST_SPEED_PER_PULSE), CFG_DATA_W'(RST_FEEDFORWARD_GAIN),
                  CFG_DATA_W'(RST_PROPORTIONAL_GAIN), CFG_DATA_W'(RST_INTEGRAL_GAIN),
                  CFG_DATA_W'(RST_CONTROL_PERIOD), CFG_DATA_W'(RST_INTEGRAL_LIMIT),
                  CFG_DATA_W'(RST_PWM_MAX), 1'b0);
    test_random_control(PHASE_ITEMS);

    send_idle_pct = IDLE_PCT;
    apply_setting('1, '1, '1, '1, '1, '1, '1, 1'b0);
    test_random_control(PHASE_ITEMS);

    send_idle_pct  = 0;
    recv_stall_pct = IDLE_PCT;
    apply_setting('0, '0, '0, '0, '0, '0, CFG_DATA_W'(1), 1'b0);
    test_random_control(PHASE_ITEMS);

    // A zero PWM ceiling forces every computed PWM to zero.
    send_idle_pct  = BOTH_IDLE_PCT;
    recv_stall_pct = BOTH_IDLE_PCT;
    apply_setting(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                  CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                  '0, 1'b0);
    test_random_control(PHASE_ITEMS);

    test_backpressure();

    wait_idle();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
